// ===== hw/rtl/shncls_pkg.sv =====
// Shared types, character weights and keyword table for the SIP header name classifier.
// No dependencies; imported by the front, queue, back and top level.
`timescale 1ns / 1ps
`default_nettype none

package shncls_pkg;

    localparam int KW_BYTES = 19;   // longest keyword in the table
    localparam int KW_LEN_W = 5;
    localparam int HASH_W   = 11;
    localparam int SLOT_W   = 8;
    localparam int WEIGHT_W = 6;

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_UNDER   = 8'h5F;
    localparam logic [7:0] UPPER_MASK   = 8'hDF;

    typedef struct packed {
        logic                bad;
        logic [WEIGHT_W-1:0] value;
    } t_weight;

    // One finished name, handed from front to back. Name bytes are
    // right-justified: byte 0 is the last character.
    typedef struct packed {
        logic                    pre_ok;   // length, characters and slot range all fine
        logic [SLOT_W-1:0]       slot;
        logic [KW_LEN_W-1:0]     len;
        logic [KW_BYTES*8-1:0]   name;
    } t_name_desc;

    typedef struct packed {
        logic                  present;
        logic [KW_LEN_W-1:0]   len;
        logic [KW_BYTES*8-1:0] text;
    } t_keyword;

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            return c & UPPER_MASK;
        end
        return c;
    endfunction

    function automatic t_weight char_weight(input logic [7:0] c);
        logic [7:0] u;
        t_weight    w;
        u = fold_upper(c);
        w.bad   = 1'b0;
        w.value = '0;
        case (u)
            8'h44:     w.value = 6'd5;    // D
            8'h46:     w.value = 6'd60;   // F
            8'h4A:     w.value = 6'd15;   // J
            8'h4B:     w.bad   = 1'b1;    // K has no weight
            8'h4C:     w.value = 6'd30;   // L
            8'h4D:     w.value = 6'd30;   // M
            8'h51:     w.value = 6'd35;   // Q
            8'h56:     w.value = 6'd25;   // V
            8'h57:     w.value = 6'd30;   // W
            8'h58:     w.value = 6'd25;   // X
            8'h59:     w.value = 6'd15;   // Y
            CHAR_DASH: w.value = 6'd0;
            CHAR_UNDER: w.value = 6'd15;
            default: begin
                if (!(u >= CHAR_UPPER_A && u <= CHAR_UPPER_Z)) begin
                    w.bad = 1'b1;
                end
            end
        endcase
        return w;
    endfunction

    function automatic t_keyword kw_make(input logic [KW_BYTES*8-1:0] text);
        t_keyword k;
        k.present = 1'b1;
        k.text    = text;
        k.len     = '0;
        for (int j = 0; j < KW_BYTES; j++) begin
            if (text[8*j +: 8] != 8'h00) begin
                k.len = KW_LEN_W'(j + 1);
            end
        end
        return k;
    endfunction

    function automatic t_keyword kw_lookup(input logic [SLOT_W-1:0] slot);
        t_keyword k;
        k = '0;
        case (slot)
            8'd2:   k = kw_make("TO");
            8'd5:   k = kw_make("ROUTE");
            8'd6:   k = kw_make("ACCEPT");
            8'd7:   k = kw_make("CONTACT");
            8'd9:   k = kw_make("DATE");
            8'd10:  k = kw_make("USER-AGENT");
            8'd12:  k = kw_make("ORGANIZATION");
            8'd13:  k = kw_make("AUTHORIZATION");
            8'd14:  k = kw_make("SUPPORTED");
            8'd16:  k = kw_make("UNSUPPORTED");
            8'd17:  k = kw_make("RECORD-ROUTE");
            8'd18:  k = kw_make("SUBSCRIPTION-STATE");
            8'd20:  k = kw_make("ACCEPT-ENCODING");
            8'd21:  k = kw_make("CONTENT-ENCODING");
            8'd22:  k = kw_make("SUBJECT");
            8'd23:  k = kw_make("PRIORITY");
            8'd24:  k = kw_make("CONTENT-DISPOSITION");
            8'd27:  k = kw_make("CONTENT-TYPE");
            8'd28:  k = kw_make("VIA");
            8'd31:  k = kw_make("SERVER");
            8'd32:  k = kw_make("EXPIRES");
            8'd37:  k = kw_make("WARNING");
            8'd38:  k = kw_make("REPLACES");
            8'd39:  k = kw_make("CSEQ");
            8'd42:  k = kw_make("REQUIRE");
            8'd44:  k = kw_make("CONTENT-LENGTH");
            8'd45:  k = kw_make("ACCEPT-LANGUAGE");
            8'd46:  k = kw_make("CONTENT-LANGUAGE");
            8'd53:  k = kw_make("REPLY-TO");
            8'd58:  k = kw_make("PROXY-AUTHENTICATE");
            8'd59:  k = kw_make("PROXY-AUTHORIZATION");
            8'd66:  k = kw_make("MIN-EXPIRES");
            8'd68:  k = kw_make("REFER-TO");
            8'd69:  k = kw_make("TIMESTAMP");
            8'd70:  k = kw_make("ERROR-INFO");
            8'd71:  k = kw_make({"IN-REPLY", "_TO"});
            8'd72:  k = kw_make("CALL-ID");
            8'd79:  k = kw_make("AUTHENTICATION-INFO");
            8'd86:  k = kw_make("RETRY-AFTER");
            8'd88:  k = kw_make("PROXY-REQUIRE");
            8'd91:  k = kw_make("REFERRED-BY");
            8'd94:  k = kw_make("FROM");
            8'd95:  k = kw_make("ALLOW");
            8'd97:  k = kw_make("MIME-VERSION");
            8'd100: k = kw_make("ALERT-INFO");
            8'd106: k = kw_make("WWW-AUTHENTICATE");
            8'd129: k = kw_make("CALL-INFO");
            8'd162: k = kw_make("MAX-FORWARDS");
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/shncls_front.sv =====
// Front end: accepts name bytes, keeps the running hash, length and byte buffer.
// Depends on shncls_pkg; pushes one descriptor per name into the queue.
`timescale 1ns / 1ps
`default_nettype none

module shncls_front
    import shncls_pkg::*;
#(
    parameter int MAX_NAME_LEN = 19,
    parameter int MIN_NAME_LEN = 2,
    parameter int TABLE_SLOTS  = 163
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_name_byte,
    input  wire logic       i_last,
    input  wire logic       i_q_full,
    output logic            o_stall,
    output logic            o_push,
    output t_name_desc      o_desc
);

    localparam int LEN_W = $clog2(MAX_NAME_LEN + 2);

    logic [HASH_W-1:0]     r_hash, n_hash;
    logic                  r_bad, n_bad;
    logic [LEN_W-1:0]      r_len, n_len;
    logic [KW_BYTES*8-1:0] r_name, n_name;

    t_weight w;
    logic    store;
    logic    accept;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign o_push  = accept && i_last;

    always_comb begin
        w      = char_weight(i_name_byte);
        store  = r_len < LEN_W'(MAX_NAME_LEN);
        n_len  = store ? r_len + LEN_W'(1) : LEN_W'(MAX_NAME_LEN + 1);
        n_bad  = r_bad | (store & w.bad);
        n_hash = r_hash;
        n_name = r_name;
        if (store) begin
            n_name = {r_name[KW_BYTES*8-9:0], i_name_byte};
            if (!w.bad) begin
                n_hash = r_hash + HASH_W'(w.value) + HASH_W'(1);
            end
        end
    end

    always_comb begin
        o_desc.pre_ok = (int'(n_len) >= MIN_NAME_LEN) && (int'(n_len) <= MAX_NAME_LEN) &&
                        (int'(n_len) <= KW_BYTES) && !n_bad &&
                        (int'(n_hash) < TABLE_SLOTS);
        o_desc.slot   = n_hash[SLOT_W-1:0];
        o_desc.len    = KW_LEN_W'(n_len);
        o_desc.name   = n_name;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
            r_bad  <= 1'b0;
            r_len  <= '0;
        end else if (accept) begin
            if (i_last) begin
                r_hash <= '0;
                r_bad  <= 1'b0;
                r_len  <= '0;
            end else begin
                r_hash <= n_hash;
                r_bad  <= n_bad;
                r_len  <= n_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_name <= n_name;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/shncls_queue.sv =====
// Two-entry queue of finished name descriptors between front and back.
// Depends on shncls_pkg for the descriptor type.
`timescale 1ns / 1ps
`default_nettype none

module shncls_queue
    import shncls_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  t_name_desc      i_desc,
    input  wire logic       i_pop,
    output logic            o_full,
    output logic            o_valid,
    output t_name_desc      o_desc
);

    t_name_desc r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_desc  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/shncls_back.sv =====
// Back end: looks up the keyword for a slot, compares it with the name, holds the result.
// Depends on shncls_pkg for the keyword table and descriptor type.
`timescale 1ns / 1ps
`default_nettype none

module shncls_back
    import shncls_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  t_name_desc             i_desc,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_matched,
    output logic [SLOT_W-1:0]      o_slot
);

    t_keyword kw;
    logic     match;
    logic     r_valid, r_matched;
    logic [SLOT_W-1:0] r_slot;

    assign o_pop     = i_q_valid && (!r_valid || !i_stall);
    assign o_valid   = r_valid;
    assign o_matched = r_matched;
    assign o_slot    = r_slot;

    always_comb begin
        kw    = kw_lookup(i_desc.slot);
        match = i_desc.pre_ok && kw.present && (kw.len == i_desc.len);
        // Bytes past the name length are stale; only the low len bytes count.
        for (int j = 0; j < KW_BYTES; j++) begin
            if (KW_LEN_W'(j) < i_desc.len &&
                fold_upper(i_desc.name[8*j +: 8]) != kw.text[8*j +: 8]) begin
                match = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_matched <= match;
            r_slot    <= match ? i_desc.slot : '0;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sip_header_name_classifier_unit.sv =====
// Top level of the SIP header name classifier: front, descriptor queue and back end.
// Depends on shncls_pkg, shncls_front, shncls_queue and shncls_back.
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+-------------------------
//   input    | i_in_valid   | o_in_stall   | i_name_byte, i_last
//   output   | o_out_valid  | i_out_stall  | o_matched, o_slot
//
// One name byte is taken per cycle, back to back, for as long as the queue has room.
// After the byte flagged last, its descriptor is written into the queue; the keyword
// compare result is then registered in the output register when the back end pops it.
// Reset is synchronous, active low; it empties the queue and clears the running hash and length.
// A stalled output holds its result; the two-entry queue absorbs up to two finished
// names before o_in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module sip_header_name_classifier_unit
    import shncls_pkg::*;
#(
    parameter int MAX_NAME_LEN = 19,
    parameter int MIN_NAME_LEN = 2,
    parameter int TABLE_SLOTS  = 163
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_name_byte,
    input  wire logic       i_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_matched,
    output logic [7:0]      o_slot
);

    t_name_desc front_desc, head_desc;
    logic       push, pop, q_full, q_valid;

    // Front: hash, length, byte buffer; one descriptor per name.
    shncls_front #(
        .MAX_NAME_LEN(MAX_NAME_LEN),
        .MIN_NAME_LEN(MIN_NAME_LEN),
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_name_byte(i_name_byte),
        .i_last     (i_last),
        .i_q_full   (q_full),
        .o_stall    (o_in_stall),
        .o_push     (push),
        .o_desc     (front_desc)
    );

    // Decouples the byte stream from the result side.
    shncls_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_desc (front_desc),
        .i_pop  (pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_desc (head_desc)
    );

    // Back: keyword table lookup and bounded compare.
    shncls_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_desc   (head_desc),
        .o_pop    (pop),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_matched(o_matched),
        .o_slot   (o_slot)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/shncls_checker.sv =====
// Port-level checks for the SIP header name classifier, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module shncls_checker #(
    parameter int TABLE_SLOTS = 163
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic [7:0] i_name_byte,
    input wire logic       i_last,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic       o_matched,
    input wire logic [7:0] o_slot
);

    // A held result must not change while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_matched) && $stable(o_slot))
        else $error("result changed while stalled");

    // An unknown name reports slot zero.
    a_unmatched_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_matched |-> o_slot == 8'd0)
        else $error("unmatched result with nonzero slot");

    // A match always names a slot inside the table.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_matched |-> int'(o_slot) < TABLE_SLOTS)
        else $error("matched slot outside the table");

    // Reset empties the result side and the queue.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("state survived reset");

endmodule

bind sip_header_name_classifier_unit shncls_checker #(
    .TABLE_SLOTS(TABLE_SLOTS)
) u_shncls_checker (.*);

`default_nettype wire

// ===== dv/tb_sip_header_name_classifier_unit.sv =====
// Self-checking testbench for sip_header_name_classifier_unit: streams header names one byte
// per item, predicts each match verdict and slot, and checks every result in order.
// Depends only on the RTL of the block (and through it on shncls_pkg).
`timescale 1ns / 1ps

module tb_sip_header_name_classifier_unit;

    localparam int MAX_LEN      = 19;    // bytes stored and hashed per name
    localparam int MIN_LEN      = 2;     // shortest name that can match
    localparam int SLOT_COUNT   = 163;   // keyword slots 0..162
    localparam int WAIT_MAX     = 17;    // longest random gap or stall per item
    localparam int RANDOM_BYTES = 750;
    localparam int DRAIN_EVERY  = 200;   // sender waits for all results this often
    localparam int STALL_LIMIT  = 1000;  // cycles with no handshake before giving up
    localparam int TAIL_CYCLES  = 8;     // edges watched for stray results after the last verdict
    localparam int REPORT_MAX   = 10;

    localparam logic [7:0] LETTER_A = 8'h41;
    localparam logic [7:0] LETTER_Z = 8'h5A;
    localparam logic [7:0] LOWER_A  = 8'h61;
    localparam logic [7:0] LOWER_Z  = 8'h7A;
    localparam logic [7:0] DASH     = 8'h2D;
    localparam logic [7:0] UNDER    = 8'h5F;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // One verdict of the block: match flag and keyword slot (0 when unmatched).
    typedef struct packed {
        logic       matched;
        logic [7:0] slot;
    } t_verdict;

    typedef logic [7:0] t_byte_q[$];

    typedef enum int {
        NAME_KEYWORD,    // a known header in random letter case
        NAME_MUTATED,    // a known header with one edit
        NAME_WORDLIKE,   // letters, dash and underscore, any length
        NAME_RAW,        // arbitrary bytes
        NAME_OVERLONG    // runs past the name store
    } t_name_kind;

    // ------------------------------------------------------------------
    // Verdict tracker: mirrors the running hash and name buffer of the
    // block, queues the verdict due for each finished name and compares
    // the block's results against that queue.
    // ------------------------------------------------------------------
    class header_verdict_board;
        string      keyword_at[SLOT_COUNT];
        int         keyword_slots[$];
        t_verdict   verdicts_due[$];
        int         mismatches;
        int         hash_total;
        bit         bad_char;
        int         name_len;
        logic [7:0] name_buf[MAX_LEN];

        function new();
            keyword_at[2]   = "TO";
            keyword_at[5]   = "ROUTE";
            keyword_at[6]   = "ACCEPT";
            keyword_at[7]   = "CONTACT";
            keyword_at[9]   = "DATE";
            keyword_at[10]  = "USER-AGENT";
            keyword_at[12]  = "ORGANIZATION";
            keyword_at[13]  = "AUTHORIZATION";
            keyword_at[14]  = "SUPPORTED";
            keyword_at[16]  = "UNSUPPORTED";
            keyword_at[17]  = "RECORD-ROUTE";
            keyword_at[18]  = "SUBSCRIPTION-STATE";
            keyword_at[20]  = "ACCEPT-ENCODING";
            keyword_at[21]  = "CONTENT-ENCODING";
            keyword_at[22]  = "SUBJECT";
            keyword_at[23]  = "PRIORITY";
            keyword_at[24]  = "CONTENT-DISPOSITION";
            keyword_at[27]  = "CONTENT-TYPE";
            keyword_at[28]  = "VIA";
            keyword_at[31]  = "SERVER";
            keyword_at[32]  = "EXPIRES";
            keyword_at[37]  = "WARNING";
            keyword_at[38]  = "REPLACES";
            keyword_at[39]  = "CSEQ";
            keyword_at[42]  = "REQUIRE";
            keyword_at[44]  = "CONTENT-LENGTH";
            keyword_at[45]  = "ACCEPT-LANGUAGE";
            keyword_at[46]  = "CONTENT-LANGUAGE";
            keyword_at[53]  = "REPLY-TO";
            keyword_at[58]  = "PROXY-AUTHENTICATE";
            keyword_at[59]  = "PROXY-AUTHORIZATION";
            keyword_at[66]  = "MIN-EXPIRES";
            keyword_at[68]  = "REFER-TO";
            keyword_at[69]  = "TIMESTAMP";
            keyword_at[70]  = "ERROR-INFO";
            keyword_at[71]  = {"IN-REPLY", "_TO"};
            keyword_at[72]  = "CALL-ID";
            keyword_at[79]  = "AUTHENTICATION-INFO";
            keyword_at[86]  = "RETRY-AFTER";
            keyword_at[88]  = "PROXY-REQUIRE";
            keyword_at[91]  = "REFERRED-BY";
            keyword_at[94]  = "FROM";
            keyword_at[95]  = "ALLOW";
            keyword_at[97]  = "MIME-VERSION";
            keyword_at[100] = "ALERT-INFO";
            keyword_at[106] = "WWW-AUTHENTICATE";
            keyword_at[129] = "CALL-INFO";
            keyword_at[162] = "MAX-FORWARDS";
            foreach (keyword_at[i]) begin
                if (keyword_at[i] != "") begin
                    keyword_slots.push_back(i);
                end
            end
            mismatches = 0;
            hash_total = 0;
            bad_char   = 1'b0;
            name_len   = 0;
        endfunction

        // only a..z fold; every other byte passes unchanged
        function logic [7:0] to_upper(logic [7:0] c);
            if (c >= LOWER_A && c <= LOWER_Z) begin
                return c - CASE_BIT;
            end
            return c;
        endfunction

        // hash weight of one byte, -1 when the byte cannot appear in a name
        function int weight_of(logic [7:0] c);
            logic [7:0] u;
            u = to_upper(c);
            if (u == DASH) begin
                return 0;
            end
            if (u == UNDER) begin
                return 15;
            end
            if (u < LETTER_A || u > LETTER_Z) begin
                return -1;
            end
            case (u)
                "D":     return 5;
                "F":     return 60;
                "J":     return 15;
                "K":     return -1;
                "L":     return 30;
                "M":     return 30;
                "Q":     return 35;
                "V":     return 25;
                "W":     return 30;
                "X":     return 25;
                "Y":     return 15;
                default: return 0;
            endcase
        endfunction

        function t_verdict classify_name();
            t_verdict v;
            string    word;
            bit       ok;
            v  = '0;
            ok = name_len >= MIN_LEN && name_len <= MAX_LEN && !bad_char &&
                 hash_total < SLOT_COUNT;
            if (ok) begin
                word = keyword_at[hash_total];
                ok   = word != "" && word.len() == name_len;
            end
            for (int i = 0; ok && i < name_len; i++) begin
                if (to_upper(name_buf[i]) != 8'(word[i])) begin
                    ok = 1'b0;
                end
            end
            if (ok) begin
                v.matched = 1'b1;
                v.slot    = 8'(hash_total);
            end
            return v;
        endfunction

        // One accepted input item.
        function void take_byte(logic [7:0] c, logic last);
            int w;
            if (name_len < MAX_LEN) begin
                w = weight_of(c);
                name_buf[name_len] = c;
                if (w < 0) begin
                    bad_char = 1'b1;
                end else begin
                    hash_total += 1 + w;
                end
                name_len++;
            end else begin
                name_len = MAX_LEN + 1;   // overlong: saturate, store nothing
            end
            if (last) begin
                verdicts_due.push_back(classify_name());
                hash_total = 0;
                bad_char   = 1'b0;
                name_len   = 0;
            end
        endfunction

        function void note_mismatch(string what);
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("%0t: %s", $time, what);
            end
        endfunction

        // One accepted result item.
        function void compare_verdict(logic matched, logic [7:0] slot);
            t_verdict want;
            if (verdicts_due.size() == 0) begin
                note_mismatch($sformatf("result with none due: matched=%0b slot=%0d",
                                        matched, slot));
                return;
            end
            want = verdicts_due.pop_front();
            if (matched !== want.matched || slot !== want.slot) begin
                note_mismatch($sformatf("expected matched=%0b slot=%0d, got matched=%0b slot=%0d",
                                        want.matched, want.slot, matched, slot));
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        function int failures();
            return mismatches + verdicts_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, DUT and channel signals
    // ------------------------------------------------------------------
    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_name_byte;
    logic       i_last;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_matched;
    logic [7:0] o_slot;

    header_verdict_board board;
    int  bytes_sent;
    int  quiet_cycles;
    bit  send_burst;   // sender runs back to back while set
    bit  recv_burst;   // receiver never stalls while set

    sip_header_name_classifier_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_name_byte (i_name_byte),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_matched   (o_matched),
        .o_slot      (o_slot)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Every DUT input is known from time zero; the tracker exists before any edge.
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_name_byte = '0;
        i_last      = 1'b0;
        i_out_stall = 1'b0;
        send_burst  = 1'b0;
        recv_burst  = 1'b0;
        bytes_sent  = 0;
        board       = new();
    end

    // Per-item wait: zero inside a burst, otherwise uniform over the full range.
    function automatic int draw_wait(bit burst);
        return burst ? 0 : int'($urandom_range(0, WAIT_MAX));
    endfunction

    // ------------------------------------------------------------------
    // Input side. valid stays high from one item straight into the next
    // when no gap is drawn, so it is never lowered and raised in one step.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        gap = draw_wait(send_burst);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_name_byte <= c;
        i_last      <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.take_byte(c, last);
        bytes_sent++;
    endtask

    task automatic send_name(input t_byte_q q);
        for (int i = 0; i < q.size(); i++) begin
            send_byte(q[i], i == q.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        t_byte_q q;
        for (int i = 0; i < s.len(); i++) begin
            q.push_back(8'(s[i]));
        end
        send_name(q);
    endtask

    // Sender holds off until every verdict due has come back.
    task automatic wait_all_verdicts();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] mixed_case(logic [7:0] c);
        if (c >= LETTER_A && c <= LETTER_Z && $urandom_range(0, 1) == 1) begin
            return c | CASE_BIT;
        end
        return c;
    endfunction

    // any letter (K included), dash or underscore
    function automatic logic [7:0] name_char();
        int idx;
        idx = $urandom_range(0, 27);
        if (idx == 26) begin
            return DASH;
        end
        if (idx == 27) begin
            return UNDER;
        end
        return mixed_case(LETTER_A + 8'(idx));
    endfunction

    function automatic t_name_kind draw_kind();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return NAME_KEYWORD;
        if (pick < 75) return NAME_MUTATED;
        if (pick < 87) return NAME_WORDLIKE;
        if (pick < 95) return NAME_RAW;
        return NAME_OVERLONG;
    endfunction

    // Mostly well-formed header names with random case; the rest are edited
    // keywords, letter soup, raw bytes and names longer than the store.
    task automatic build_name(input t_name_kind kind, output t_byte_q q);
        string word;
        int    n;
        int    pos;
        q.delete();
        word = board.keyword_at[board.keyword_slots[
                   $urandom_range(0, board.keyword_slots.size() - 1)]];
        case (kind)
            NAME_KEYWORD, NAME_MUTATED, NAME_OVERLONG: begin
                for (int i = 0; i < word.len(); i++) begin
                    q.push_back(mixed_case(8'(word[i])));
                end
            end
            NAME_WORDLIKE: begin
                n = $urandom_range(1, MAX_LEN + 2);
                repeat (n) q.push_back(name_char());
            end
            default: begin
                n = $urandom_range(1, 6);
                repeat (n) q.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        if (kind == NAME_MUTATED) begin
            pos = $urandom_range(0, q.size() - 1);
            case ($urandom_range(0, 3))
                0: q[pos] = name_char();
                1: if (q.size() > 1) void'(q.pop_back());
                2: q.push_back(name_char());
                default: q[pos] = mixed_case("K");   // the one letter with no weight
            endcase
        end
        if (kind == NAME_OVERLONG) begin
            n = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
            while (q.size() < n) q.push_back(name_char());
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: stall drawn per result, then held low until one lands.
    // ------------------------------------------------------------------
    initial begin : result_side
        int hold;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 7) == 0) begin
                recv_burst = !recv_burst;
            end
            hold = draw_wait(recv_burst);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            board.compare_verdict(o_matched, o_slot);
        end
    end

    // Watchdog: any handshake on either channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end
    initial quiet_cycles = 0;

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_byte_q q;
        int      next_drain;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed names
        send_text("To");             // shortest keyword, mixed case
        send_byte(8'h00, 1'b1);      // lone byte: too short
        send_text("vIa");            // matched
        send_text("ABC");            // slot with no keyword
        send_text("FFF");            // sum beyond the last slot
        send_text("xK");             // K has no weight
        send_text("_-");             // lands on a keyword of another length
        q = '{8'hFF, 8'h80};         // invalid bytes, top bit set
        send_name(q);
        send_text("cseq");           // matched, lower case
        wait_all_verdicts();

        // Random names; sender bursts are chosen per name
        next_drain = bytes_sent + DRAIN_EVERY;
        while (bytes_sent < RANDOM_BYTES) begin
            send_burst = ($urandom_range(0, 3) == 0);
            build_name(draw_kind(), q);
            send_name(q);
            if (bytes_sent >= next_drain) begin
                wait_all_verdicts();
                next_drain = bytes_sent + DRAIN_EVERY;
            end
        end

        // Let the last verdicts arrive, then watch a few more edges for strays.
        wait_all_verdicts();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.failures() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sip_header_name_classifier_unit.f =====
hw/rtl/shncls_pkg.sv
hw/rtl/shncls_front.sv
hw/rtl/shncls_queue.sv
hw/rtl/shncls_back.sv
hw/rtl/sip_header_name_classifier_unit.sv
hw/rtl/shncls_checker.sv
dv/tb_sip_header_name_classifier_unit.sv
